// ===== src/wcl_pkg.sv =====
package wcl_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned MAX_BEACONS = 16;

  localparam int unsigned CountW = $clog2(MAX_BEACONS + 1);

  localparam int unsigned DivSteps   = 64;
  localparam int unsigned StepW      = $clog2(DivSteps + 1);
  localparam int unsigned RecipLinSteps  = 2 * FRAC_BITS + 1;
  localparam int unsigned RecipQuadSteps = 3 * FRAC_BITS + 1;

  localparam logic [39:0] WSUM_MAX = '1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_ZERO_DIST = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic clear;
    logic take;
    logic zero;
    logic add;
  } acc_ctrl_t;

  typedef struct packed {
    logic full;
    logic done;
    logic zero_seen;
    logic overflow;
  } acc_stat_t;

endpackage

// ===== src/wcl_div.sv =====
module wcl_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [63:0]              dividend_i,
  input  logic [63:0]              divisor_i,
  input  logic [wcl_pkg::StepW-1:0] steps_i,
  output logic                     done_o,
  output logic [31:0]              quot_o,
  output logic                     sat_o
);
  import wcl_pkg::*;

  logic             busy_q;
  logic [StepW-1:0] cnt_q;
  logic [63:0]      num_q;
  logic [63:0]      den_q;
  logic [63:0]      rem_q;
  logic [31:0]      quot_q;
  logic             sat_q;

  logic [64:0] rem_shift;
  logic [64:0] rem_diff;
  logic        ge;

  assign rem_shift = {rem_q, num_q[63]};
  assign rem_diff  = rem_shift - {1'b0, den_q};
  assign ge        = (rem_shift >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= dividend_i;
      den_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
      sat_q  <= 1'b0;
    end else if (busy_q && cnt_q != '0) begin
      num_q  <= {num_q[62:0], 1'b0};
      rem_q  <= ge ? rem_diff[63:0] : rem_shift[63:0];
      quot_q <= {quot_q[30:0], ge};
      sat_q  <= sat_q | quot_q[31];
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quot_q;
  assign sat_o  = sat_q;

endmodule

// ===== src/wcl_acc.sv =====
module wcl_acc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wcl_pkg::acc_ctrl_t   ctrl_i,
  input  logic [31:0]          weight_i,
  input  logic signed [31:0]   x_i,
  input  logic signed [31:0]   y_i,
  output wcl_pkg::acc_stat_t   stat_o,
  output logic [39:0]          weight_sum_o,
  output logic signed [63:0]   x_sum_o,
  output logic signed [63:0]   y_sum_o
);
  import wcl_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_X,
    PH_Y
  } phase_e;

  phase_e             phase_q;
  logic [39:0]        wsum_q;
  logic signed [63:0] xsum_q;
  logic signed [63:0] ysum_q;
  logic [CountW-1:0]  cnt_q;
  logic               zero_q;
  logic               ovf_q;

  logic [31:0]        w_q;
  logic signed [31:0] y_q;
  logic signed [63:0] prod_q;

  logic signed [31:0] mul_a;
  logic signed [32:0] mul_w;
  logic signed [64:0] mul_full;
  logic [40:0]        wsum_add;
  logic [64:0]        sum_res;

  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic [64:0] s;
    logic [64:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r = {1'b1, s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}};
    end else begin
      r = {1'b0, s[63:0]};
    end
    return r;
  endfunction

  assign mul_a    = (phase_q == PH_IDLE) ? x_i : y_q;
  assign mul_w    = {1'b0, (phase_q == PH_IDLE) ? weight_i : w_q};
  assign mul_full = mul_a * mul_w;
  assign wsum_add = {1'b0, wsum_q} + {9'd0, weight_i};
  assign sum_res  = sat_add((phase_q == PH_X) ? xsum_q : ysum_q, prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      wsum_q  <= '0;
      xsum_q  <= '0;
      ysum_q  <= '0;
      cnt_q   <= '0;
      zero_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (ctrl_i.clear) begin
      phase_q <= PH_IDLE;
      wsum_q  <= '0;
      xsum_q  <= '0;
      ysum_q  <= '0;
      cnt_q   <= '0;
      zero_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      if (ctrl_i.take) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (ctrl_i.zero) begin
        zero_q <= 1'b1;
      end
      unique case (phase_q)
        PH_IDLE: begin
          if (ctrl_i.add) begin
            phase_q <= PH_X;
            if (wsum_add[40]) begin
              wsum_q <= WSUM_MAX;
              ovf_q  <= 1'b1;
            end else begin
              wsum_q <= wsum_add[39:0];
            end
          end
        end
        PH_X: begin
          xsum_q  <= sum_res[63:0];
          ovf_q   <= ovf_q | sum_res[64];
          phase_q <= PH_Y;
        end
        PH_Y: begin
          ysum_q  <= sum_res[63:0];
          ovf_q   <= ovf_q | sum_res[64];
          phase_q <= PH_IDLE;
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == PH_IDLE && ctrl_i.add) begin
      w_q <= weight_i;
      y_q <= y_i;
    end
    prod_q <= mul_full[63:0];
  end

  assign stat_o.full      = (cnt_q >= CountW'(MAX_BEACONS));
  assign stat_o.done      = (phase_q == PH_Y);
  assign stat_o.zero_seen = zero_q;
  assign stat_o.overflow  = ovf_q;
  assign weight_sum_o     = wsum_q;
  assign x_sum_o          = xsum_q;
  assign y_sum_o          = ysum_q;

endmodule

// ===== src/weighted_centroid_locator.sv =====
// Inverse-distance weighted centroid of a set of beacons.
// Input channel (in_valid_i / in_ready_o) takes one beacon item: X, Y,
// distance and a last flag. Output channel (out_valid_o / out_ready_i)
// gives one centroid item with status for each item marked last.
// cfg_we_i / cfg_wdata_i write the weighting mode (0 is 1/d, 1 is 1/d^2);
// write it only while the block is idle.
// One item is worked at a time. A beacon with nonzero distance runs
// through the shared radix-2 divider, which forms the weight one
// quotient bit per cycle (33 steps in linear mode, 49 in quadratic
// mode); a beacon with zero distance, or beyond the sixteenth, skips
// the divider. A last item adds the two 64-step centroid divisions on
// the same divider, which are skipped when the weight sum is zero.
// The result sits in an output register; the next beacon is accepted
// while it waits. A finished set whose result finds the output register
// still full holds until the receiver takes the earlier item.
// Reset clears the sums, count, flags, mode and the output valid.
module weighted_centroid_locator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] beacon_x_i,
  input  logic signed [31:0] beacon_y_i,
  input  logic [31:0]        beacon_distance_i,
  input  logic               last_beacon_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] position_x_o,
  output logic signed [31:0] position_y_o,
  output logic [1:0]         status_o
);
  import wcl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_RECIP,
    ST_ACCUM,
    ST_CENTX,
    ST_DIVX,
    ST_CENTY,
    ST_DIVY,
    ST_OUT
  } state_e;

  state_e             state_q;
  logic               mode_q;
  logic               out_valid_q;
  logic signed [31:0] pos_x_q;
  logic signed [31:0] pos_y_q;
  logic [1:0]         status_q;
  logic signed [31:0] res_x_q;
  logic signed [31:0] res_y_q;

  logic signed [31:0] x_q;
  logic signed [31:0] y_q;
  logic [31:0]        d_q;
  logic               last_q;

  acc_ctrl_t          acc_ctrl;
  acc_stat_t          acc_stat;
  logic [39:0]        wsum;
  logic signed [63:0] xsum;
  logic signed [63:0] ysum;

  logic               accept;
  logic               div_start;
  logic [63:0]        div_dividend;
  logic [63:0]        div_divisor;
  logic [StepW-1:0]   div_steps;
  logic               div_done;
  logic [31:0]        div_quot;
  logic               div_sat;
  logic [31:0]        weight;
  logic [63:0]        d_sq;
  logic [63:0]        xmag;
  logic [63:0]        ymag;
  logic               out_free;
  logic [1:0]         status_d;

  function automatic logic [31:0] clamp_q(input logic neg, input logic [31:0] q,
                                          input logic sat);
    logic [31:0] r;
    if (neg) begin
      if (sat || q > 32'h8000_0000) begin
        r = 32'h8000_0000;
      end else begin
        r = 32'd0 - q;
      end
    end else begin
      if (sat || q[31]) begin
        r = 32'h7FFF_FFFF;
      end else begin
        r = q;
      end
    end
    return r;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign weight     = div_sat ? 32'hFFFF_FFFF : div_quot;
  assign d_sq       = d_q * d_q;
  assign xmag       = xsum[63] ? 64'd0 - xsum : xsum;
  assign ymag       = ysum[63] ? 64'd0 - ysum : ysum;

  always_comb begin
    acc_ctrl       = '0;
    acc_ctrl.take  = accept && !acc_stat.full;
    acc_ctrl.zero  = accept && !acc_stat.full && (beacon_distance_i == '0);
    acc_ctrl.add   = (state_q == ST_RECIP) && div_done;
    acc_ctrl.clear = (state_q == ST_OUT) && out_free;
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {1'b1, 63'd0};
    div_divisor  = mode_q ? d_sq : {32'd0, d_q};
    div_steps    = mode_q ? StepW'(RecipQuadSteps) : StepW'(RecipLinSteps);
    case (state_q)
      ST_PREP: div_start = 1'b1;
      ST_CENTX: begin
        div_start    = (wsum != '0);
        div_dividend = xmag;
        div_divisor  = {24'd0, wsum};
        div_steps    = StepW'(DivSteps);
      end
      ST_CENTY: begin
        div_start    = 1'b1;
        div_dividend = ymag;
        div_divisor  = {24'd0, wsum};
        div_steps    = StepW'(DivSteps);
      end
      default: div_start = 1'b0;
    endcase
  end

  always_comb begin
    if (acc_stat.zero_seen) begin
      status_d = STATUS_ZERO_DIST;
    end else if (acc_stat.overflow) begin
      status_d = STATUS_OVERFLOW;
    end else if (wsum == '0) begin
      status_d = STATUS_EMPTY;
    end else begin
      status_d = STATUS_OK;
    end
  end

  wcl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .sat_o      (div_sat)
  );

  wcl_acc u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (acc_ctrl),
    .weight_i     (weight),
    .x_i          (x_q),
    .y_i          (y_q),
    .stat_o       (acc_stat),
    .weight_sum_o (wsum),
    .x_sum_o      (xsum),
    .y_sum_o      (ysum)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= beacon_x_i;
      y_q    <= beacon_y_i;
      d_q    <= beacon_distance_i;
      last_q <= last_beacon_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      status_q    <= STATUS_OK;
      res_x_q     <= '0;
      res_y_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (!acc_stat.full && beacon_distance_i != '0) begin
              state_q <= ST_PREP;
            end else if (last_beacon_i) begin
              state_q <= ST_CENTX;
            end
          end
        end
        ST_PREP: state_q <= ST_RECIP;
        ST_RECIP: begin
          if (div_done) begin
            state_q <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          if (acc_stat.done) begin
            state_q <= last_q ? ST_CENTX : ST_IDLE;
          end
        end
        ST_CENTX: begin
          if (wsum == '0) begin
            res_x_q <= '0;
            res_y_q <= '0;
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_DIVX;
          end
        end
        ST_DIVX: begin
          if (div_done) begin
            res_x_q <= clamp_q(xsum[63], div_quot, div_sat);
            state_q <= ST_CENTY;
          end
        end
        ST_CENTY: state_q <= ST_DIVY;
        ST_DIVY: begin
          if (div_done) begin
            res_y_q <= clamp_q(ysum[63], div_quot, div_sat);
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            pos_x_q     <= res_x_q;
            pos_y_q     <= res_y_q;
            status_q    <= status_d;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign position_x_o = pos_x_q;
  assign position_y_o = pos_y_q;
  assign status_o     = status_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import wcl_pkg::*;

  localparam int unsigned ClkPeriod    = 8;
  localparam int unsigned SettleCycles = 250;
  localparam int unsigned HoldCycles   = 1500;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [1:0]  status;
  } fix_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] beacon_x_i;
  logic signed [31:0] beacon_y_i;
  logic [31:0]        beacon_distance_i;
  logic               last_beacon_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] position_x_o;
  logic signed [31:0] position_y_o;
  logic [1:0]         status_o;

  fix_t        fix_q[$];
  int unsigned mismatches;
  bit          calm;
  bit          rx_hold_req;

  logic        quad_mode;
  logic [39:0] weight_acc;
  logic [63:0] x_acc;
  logic [63:0] y_acc;
  int unsigned held_beacons;
  logic        zero_seen;
  logic        sum_sat;

  weighted_centroid_locator u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .beacon_x_i        (beacon_x_i),
    .beacon_y_i        (beacon_y_i),
    .beacon_distance_i (beacon_distance_i),
    .last_beacon_i     (last_beacon_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .position_x_o      (position_x_o),
    .position_y_o      (position_y_o),
    .status_o          (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #(ClkPeriod * 2_000_000);
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] beacon_weight(input logic [31:0] distance, input logic quad);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    den = {96'd0, distance};
    if (quad) begin
      num = 128'd1 << (3 * FRAC_BITS);
      den = den * den;
    end else begin
      num = 128'd1 << (2 * FRAC_BITS);
    end
    q = num / den;
    return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b,
                                              output logic sat);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    sat = s[64] != s[63];
    if (!sat) return s[63:0];
    return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  endfunction

  function automatic logic [31:0] centroid_coord(input logic [63:0] s, input logic [39:0] w);
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] neg_q;
    mag = s[63] ? (64'd0 - s) : s;
    q = mag / {24'd0, w};
    if (s[63]) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      neg_q = 64'd0 - q;
      return neg_q[31:0];
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  task automatic start_new_set();
    weight_acc   = '0;
    x_acc        = '0;
    y_acc        = '0;
    held_beacons = 0;
    zero_seen    = 1'b0;
    sum_sat      = 1'b0;
  endtask

  task automatic accumulate_beacon(input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] distance, input logic is_last);
    logic [31:0] w;
    logic [40:0] wsum;
    logic [63:0] prod;
    logic        sat;
    fix_t        res;
    if (held_beacons < MAX_BEACONS) begin
      held_beacons++;
      if (distance == 32'd0) begin
        zero_seen = 1'b1;
      end else begin
        w = beacon_weight(distance, quad_mode);
        wsum = {1'b0, weight_acc} + {9'd0, w};
        if (wsum > {1'b0, WSUM_MAX}) begin
          weight_acc = WSUM_MAX;
          sum_sat = 1'b1;
        end else begin
          weight_acc = wsum[39:0];
        end
        prod = {{32{x[31]}}, x} * {32'd0, w};
        x_acc = add_clamped(x_acc, prod, sat);
        sum_sat |= sat;
        prod = {{32{y[31]}}, y} * {32'd0, w};
        y_acc = add_clamped(y_acc, prod, sat);
        sum_sat |= sat;
      end
    end
    if (is_last) begin
      if (zero_seen) res.status = STATUS_ZERO_DIST;
      else if (sum_sat) res.status = STATUS_OVERFLOW;
      else if (weight_acc == '0) res.status = STATUS_EMPTY;
      else res.status = STATUS_OK;
      if (weight_acc == '0) begin
        res.x = '0;
        res.y = '0;
      end else begin
        res.x = centroid_coord(x_acc, weight_acc);
        res.y = centroid_coord(y_acc, weight_acc);
      end
      fix_q.push_back(res);
      start_new_set();
    end
  endtask

  task automatic send_beacon(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] distance, input logic is_last);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    beacon_x_i        <= x;
    beacon_y_i        <= y;
    beacon_distance_i <= distance;
    last_beacon_i     <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    accumulate_beacon(x, y, distance, is_last);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (fix_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_weighting(input logic mode);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    quad_mode = mode;
  endtask

  function automatic logic [31:0] rand_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return $urandom;
    if (r < 28) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
  endfunction

  function automatic logic [31:0] rand_dist();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return 32'd0;
    if (r < 10) return $urandom_range(1, 255);
    if (r < 22) return $urandom;
    if (r < 26) return $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
    return $urandom_range(32'h0000_4000, 32'h00FF_FFFF);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $display("%0t: %s expected %h, got %h", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin : check_result
    fix_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (fix_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item x %h y %h status %0d, expected none", $time,
                 position_x_o, position_y_o, status_o);
      end else begin
        want = fix_q.pop_front();
        if (position_x_o !== want.x) report_mismatch("position_x", want.x, position_x_o);
        if (position_y_o !== want.y) report_mismatch("position_y", want.y, position_y_o);
        if (status_o !== want.status)
          report_mismatch("status", {30'd0, want.status}, {30'd0, status_o});
      end
    end
  end

  initial begin : receiver
    int unsigned run_left;
    int unsigned idle_left;
    out_ready_i = 1'b0;
    run_left    = 0;
    idle_left   = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        idle_left = HoldCycles;
      end
      if (idle_left > 0) begin
        idle_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left  = $urandom_range(0, 24);
          idle_left = gap_len();
        end
      end
    end
  end

  task automatic test_linear_extremes();
    set_weighting(1'b0);
    send_beacon(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 1'b1);
    send_beacon(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 1'b0);
    send_beacon(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 1'b1);
    send_beacon(32'h8000_0000, 32'h0000_0000, 32'd1, 1'b0);
    send_beacon(32'h8000_0000, 32'h0000_0000, 32'd2, 1'b1);
    send_beacon(32'h1234_0000, 32'hFFFF_FFFB, 32'd0, 1'b0);
    send_beacon(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1'b1);
    send_beacon(32'h0000_0000, 32'h0000_0000, 32'd0, 1'b0);
    send_beacon(32'h8000_0000, 32'h8000_0000, 32'd1, 1'b0);
    send_beacon(32'h8000_0000, 32'h8000_0000, 32'd1, 1'b1);
    send_beacon(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
    send_beacon(32'h0000_0000, 32'h0000_0000, 32'd0, 1'b1);
    send_beacon(32'h0003_0000, 32'hFFFB_0000, 32'h0001_0000, 1'b0);
    send_beacon(32'hFFFE_0000, 32'h0004_0000, 32'h0003_0000, 1'b1);
  endtask

  task automatic test_quadratic_weights();
    set_weighting(1'b1);
    send_beacon(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1'b1);
    send_beacon(32'h0005_0000, 32'hFFFD_0000, 32'h0100_0000, 1'b1);
    send_beacon(32'h0001_0000, 32'h0001_0000, 32'h0100_0001, 1'b1);
    send_beacon(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_beacon(32'h0000_0000, 32'h0000_0000, 32'd1, 1'b1);
    send_beacon(32'hFFF9_0000, 32'h0009_0000, 32'h0001_8000, 1'b0);
    send_beacon(32'h0003_0000, 32'h0001_0000, 32'h0000_8000, 1'b1);
  endtask

  task automatic test_beacon_limit();
    set_weighting(1'b0);
    for (int i = 0; i < MAX_BEACONS; i++)
      send_beacon(rand_coord(), rand_coord(), 32'h0001_0000 + i * 32'h0000_4000, 1'b0);
    send_beacon(32'h0000_0000, 32'h0000_0000, 32'd0, 1'b0);
    send_beacon(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 1'b1);
  endtask

  task automatic test_random_sets(input logic mode, input int unsigned n_items,
                                  input bit no_gaps);
    int unsigned sent;
    int unsigned set_len;
    int unsigned r;
    set_weighting(mode);
    calm = no_gaps;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 10) set_len = 1;
      else if (r < 85) set_len = $urandom_range(2, 6);
      else if (r < 95) set_len = $urandom_range(7, MAX_BEACONS);
      else set_len = $urandom_range(MAX_BEACONS + 1, MAX_BEACONS + 4);
      for (int i = 0; i < set_len; i++)
        send_beacon(rand_coord(), rand_coord(), rand_dist(), i == set_len - 1);
      sent += set_len;
    end
    calm = 1'b0;
  endtask

  task automatic test_output_backpressure();
    set_weighting(1'b1);
    rx_hold_req = 1'b1;
    repeat (8)
      send_beacon(rand_coord(), rand_coord(), 32'h0001_0000 + $urandom_range(0, 32'hFFFF), 1'b1);
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = 1'b0;
    in_valid_i        = 1'b0;
    beacon_x_i        = '0;
    beacon_y_i        = '0;
    beacon_distance_i = '0;
    last_beacon_i     = 1'b0;
    calm              = 1'b0;
    rx_hold_req       = 1'b0;
    mismatches        = 0;
    quad_mode         = 1'b0;
    start_new_set();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_linear_extremes();
    test_quadratic_weights();
    test_beacon_limit();
    test_random_sets(1'b0, 130, 1'b0);
    test_random_sets(1'b1, 130, 1'b0);
    test_random_sets(1'b1, 70, 1'b1);
    test_output_backpressure();
    test_random_sets(1'b0, 60, 1'b0);

    wait_idle();
    if (mismatches == 0 && fix_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/wcl_pkg.sv
src/wcl_div.sv
src/wcl_acc.sv
src/weighted_centroid_locator.sv
test/tb_top.sv
